// ===== hw/rtl/wcc_pkg.sv =====
`timescale 1ns / 1ps

package wcc_pkg;

    // Elapsed-time counter width
    localparam int TIMER_WIDTH = 24;

    // Register field widths
    localparam int DUR_W    = 24;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WASH_DURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_DURATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PERIOD = 2'd2;

    // Register reset values
    localparam logic [DUR_W-1:0]    WASH_DURATION_RST  = 24'd20000;
    localparam logic [DUR_W-1:0]    SPIN_DURATION_RST  = 24'd15000;
    localparam logic [PERIOD_W-1:0] REVERSE_PERIOD_RST = 16'd5000;

    // Cycle phase codes
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FILL  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WASH  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DRAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SPIN  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;

    // Drive latch bit positions
    localparam int LATCH_W = 6;
    localparam int L_CW    = 0;
    localparam int L_CCW   = 1;
    localparam int L_SPIN  = 2;
    localparam int L_INLET = 3;
    localparam int L_DRAIN = 4;
    localparam int L_DRYER = 5;

    typedef struct packed {
        logic water_full;
        logic manual_wash;
        logic manual_spin;
        logic manual_fill;
        logic manual_drain;
        logic manual_dryer;
        logic start_cycle;
    } t_in_item;

    typedef struct packed {
        logic               drum_clockwise;
        logic               drum_counterclockwise;
        logic               spin_motor;
        logic               inlet_valve;
        logic               drain_pump;
        logic               dryer_heater;
        logic [PHASE_W-1:0] cycle_phase;
        logic               auto_running;
    } t_out_item;

    typedef struct packed {
        logic [DUR_W-1:0]    wash_duration;
        logic [DUR_W-1:0]    spin_duration;
        logic [PERIOD_W-1:0] reverse_period;
    } t_cfg;

endpackage

// ===== hw/rtl/wcc_rev_timer.sv =====
`timescale 1ns / 1ps

module wcc_rev_timer import wcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_step,
    input  logic                i_clear,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_bit_adv
);

    logic [PERIOD_W-1:0] r_count;
    logic                r_bit;
    logic [PERIOD_W-1:0] n_count;
    logic                n_bit;
    logic [PERIOD_W-1:0] w_inc;
    logic [PERIOD_W-1:0] w_adv_count;
    logic                w_adv_bit;

    // Advance one tick: wrap at the period, a zero period toggles every tick
    always_comb begin
        w_inc = r_count + PERIOD_W'(1);
        if (w_inc >= i_period || w_inc == '0) begin
            w_adv_count = '0;
            w_adv_bit   = ~r_bit;
        end else begin
            w_adv_count = w_inc;
            w_adv_bit   = r_bit;
        end
    end

    assign o_bit_adv = i_step ? w_adv_bit : r_bit;

    // Clear on phase entry, after the advance
    always_comb begin
        n_count = r_count;
        n_bit   = r_bit;
        if (i_tick) begin
            if (i_clear) begin
                n_count = '0;
                n_bit   = 1'b0;
            end else if (i_step) begin
                n_count = w_adv_count;
                n_bit   = w_adv_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bit   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_bit   <= n_bit;
        end
    end

endmodule

// ===== hw/rtl/wcc_core.sv =====
`timescale 1ns / 1ps

module wcc_core import wcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_tick,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int CMP_W = (TIMER_WIDTH > DUR_W) ? TIMER_WIDTH : DUR_W;
    localparam logic [TIMER_WIDTH-1:0] TIME_MAX = {TIMER_WIDTH{1'b1}};

    logic                   r_auto;
    logic [PHASE_W-1:0]     r_phase;
    logic [TIMER_WIDTH-1:0] r_time;
    logic [LATCH_W-1:0]     r_latch;

    logic                   n_auto;
    logic [PHASE_W-1:0]     n_phase;
    logic [TIMER_WIDTH-1:0] n_time;
    logic [LATCH_W-1:0]     n_latch;

    logic [TIMER_WIDTH-1:0] w_time_inc;
    logic                   w_enter;
    logic                   w_wash_step;
    logic                   w_free_bit;
    logic                   w_wash_bit;

    // Free-running reversal for manual wash
    wcc_rev_timer u_free_rev (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (i_tick),
        .i_step    (1'b1),
        .i_clear   (1'b0),
        .i_period  (i_cfg.reverse_period),
        .o_bit_adv (w_free_bit)
    );

    // Reversal for the automatic wash phase
    assign w_wash_step = r_auto && (r_phase == PH_WASH);

    wcc_rev_timer u_wash_rev (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (i_tick),
        .i_step    (w_wash_step),
        .i_clear   (w_enter),
        .i_period  (i_cfg.reverse_period),
        .o_bit_adv (w_wash_bit)
    );

    // Saturating elapsed time
    assign w_time_inc = (r_time == TIME_MAX) ? r_time : r_time + TIMER_WIDTH'(1);

    // One tick: start, manual overrides, then the automatic cycle
    always_comb begin
        n_auto  = r_auto;
        n_phase = r_phase;
        n_latch = r_latch;
        w_enter = 1'b0;

        if (i_item.start_cycle) begin
            n_auto  = 1'b1;
            n_phase = PH_FILL;
            w_enter = 1'b1;
        end

        priority if (i_item.manual_wash) begin
            n_latch[L_CW]  = ~w_free_bit;
            n_latch[L_CCW] = w_free_bit;
        end else if (i_item.manual_spin) begin
            n_latch[L_SPIN] = 1'b1;
        end else if (i_item.manual_fill) begin
            n_latch[L_INLET] = 1'b1;
        end else if (i_item.manual_drain) begin
            n_latch[L_DRAIN] = 1'b1;
        end else if (i_item.manual_dryer) begin
            n_latch[L_DRYER] = 1'b1;
        end else begin
            n_latch = '0;
        end

        // Phase logic only runs when start did not fire this tick, except fill
        if (n_auto) begin
            case (n_phase)
                PH_FILL: begin
                    n_latch[L_INLET] = 1'b1;
                    if (i_item.water_full) begin
                        n_phase = PH_WASH;
                        w_enter = 1'b1;
                    end
                end
                PH_WASH: begin
                    n_latch[L_CW]  = ~w_wash_bit;
                    n_latch[L_CCW] = w_wash_bit;
                    if (CMP_W'(w_time_inc) > CMP_W'(i_cfg.wash_duration)) begin
                        n_phase = PH_DRAIN;
                        w_enter = 1'b1;
                    end
                end
                PH_DRAIN: begin
                    n_latch[L_DRAIN] = 1'b1;
                    if (!i_item.water_full) begin
                        n_phase = PH_SPIN;
                        w_enter = 1'b1;
                    end
                end
                PH_SPIN: begin
                    n_latch[L_SPIN] = 1'b1;
                    if (CMP_W'(w_time_inc) > CMP_W'(i_cfg.spin_duration)) begin
                        n_phase = PH_DONE;
                        n_auto  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        n_time = w_enter ? '0 : w_time_inc;
    end

    // Commit state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto  <= 1'b0;
            r_phase <= PH_IDLE;
            r_time  <= '0;
            r_latch <= '0;
        end else if (i_tick) begin
            r_auto  <= n_auto;
            r_phase <= n_phase;
            r_time  <= n_time;
            r_latch <= n_latch;
        end
    end

    // Result is the state after the tick
    always_comb begin
        o_result.drum_clockwise        = n_latch[L_CW];
        o_result.drum_counterclockwise = n_latch[L_CCW];
        o_result.spin_motor            = n_latch[L_SPIN];
        o_result.inlet_valve           = n_latch[L_INLET];
        o_result.drain_pump            = n_latch[L_DRAIN];
        o_result.dryer_heater          = n_latch[L_DRYER];
        o_result.cycle_phase           = n_phase;
        o_result.auto_running          = n_auto;
    end

endmodule

// ===== hw/rtl/washer_cycle_controller.sv =====
`timescale 1ns / 1ps
// Path from item accept to result valid: input register, then result register.
// Throughput: one item per cycle while i_out_stall stays low; a one-entry skid stage
// keeps input open for one stalled result and holds off further ticks until it drains.
// Reset: synchronous active-low i_rst_n clears the cycle state, latches and
// handshake valids and loads the default durations and reversal period.
module washer_cycle_controller import wcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    logic      w_in_take;
    logic      w_tick;
    logic      w_out_free;
    t_out_item w_result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wash_duration  <= WASH_DURATION_RST;
            r_cfg.spin_duration  <= SPIN_DURATION_RST;
            r_cfg.reverse_period <= REVERSE_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WASH_DURATION:  r_cfg.wash_duration  <= i_cfg_data[DUR_W-1:0];
                CFG_SPIN_DURATION:  r_cfg.spin_duration  <= i_cfg_data[DUR_W-1:0];
                CFG_REVERSE_PERIOD: r_cfg.reverse_period <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Tick fires when the input stage holds an item and the skid is empty
    assign w_tick     = r_in_valid && !r_skid_valid;
    assign o_in_stall = r_in_valid && r_skid_valid;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || w_tick) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_item;
        end
    end

    wcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_tick),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register with skid
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_tick;
            r_skid_valid <= 1'b0;
        end else if (w_tick) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_tick) begin
                r_out <= w_result;
            end
        end else if (w_tick) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
